### hw/rtl/afc_pkg.sv
// afc_pkg: shared types, constants and helpers for the affine transform composer
// no dependencies; used by every module under hw/rtl except afc_delay
package afc_pkg;

  typedef struct packed {
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic signed [31:0] rotation_deg;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] skew_x_deg;
    logic signed [31:0] skew_y_deg;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
  } item_t;

  typedef struct packed {
    logic signed [31:0] m_a;
    logic signed [31:0] m_b;
    logic signed [31:0] m_tx;
    logic signed [31:0] m_c;
    logic signed [31:0] m_d;
    logic signed [31:0] m_ty;
    logic               overflow;
  } matrix_t;

  localparam int LANE_W = 34;
  localparam int MAG_W  = LANE_W;
  localparam int DIV_STEPS = 32;

  localparam logic signed [LANE_W-1:0] CORDIC_K0 = 34'sd652032874;
  localparam logic signed [31:0] FX_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] FX_MIN = 32'sh80000000;
  localparam logic signed [71:0] WIDE_MAX = 72'sd2147483647;
  localparam logic signed [71:0] WIDE_MIN = -72'sd2147483648;

  // one cordic lane: vector, residual angle, half-turn fold and skew-zero marks
  typedef struct packed {
    logic signed [LANE_W-1:0] x;
    logic signed [LANE_W-1:0] y;
    logic signed [LANE_W-1:0] theta;
    logic                     neg;
    logic                     zero;
  } lane_t;

  // one divider step: partial remainder, dividend bits / quotient bits, divisor, flags
  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [31:0]      dq;
    logic [MAG_W-1:0] v;
    logic             big;
    logic             czero;
    logic             sneg;
    logic             qneg;
    logic             zero;
  } div_t;

  typedef struct packed {
    logic               ov;
    logic signed [31:0] val;
  } sat_t;

  // arctan in units of 2^-32 turn
  function automatic logic [29:0] atan_turn(input int idx);
    logic [29:0] a;
    case (idx)
      0:  a = 30'd536870912;
      1:  a = 30'd316933406;
      2:  a = 30'd167458907;
      3:  a = 30'd85004756;
      4:  a = 30'd42667331;
      5:  a = 30'd21354465;
      6:  a = 30'd10679838;
      7:  a = 30'd5340245;
      8:  a = 30'd2670163;
      9:  a = 30'd1335087;
      10: a = 30'd667544;
      11: a = 30'd333772;
      12: a = 30'd166886;
      13: a = 30'd83443;
      14: a = 30'd41722;
      15: a = 30'd20861;
      16: a = 30'd10430;
      17: a = 30'd5215;
      18: a = 30'd2608;
      19: a = 30'd1304;
      20: a = 30'd652;
      21: a = 30'd326;
      22: a = 30'd163;
      23: a = 30'd81;
      24: a = 30'd41;
      25: a = 30'd20;
      26: a = 30'd10;
      27: a = 30'd5;
      28: a = 30'd3;
      29: a = 30'd1;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

  function automatic sat_t sat32(input logic signed [71:0] v);
    sat_t r;
    if (v > WIDE_MAX) begin
      r.ov  = 1'b1;
      r.val = FX_MAX;
    end else if (v < WIDE_MIN) begin
      r.ov  = 1'b1;
      r.val = FX_MIN;
    end else begin
      r.ov  = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/afc_delay.sv
// afc_delay: enabled shift line that aligns side data with the cordic and divider chains
// no dependencies
module afc_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] tap [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  assign q = tap[DEPTH-1];

endmodule

### hw/rtl/afc_angle.sv
// afc_angle: degrees to folded binary angle, three stages, plus skew-at-ninety detection
// depends on afc_pkg
module afc_angle #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [32:0]  deg,
  output afc_pkg::lane_t      lane
);
  import afc_pkg::*;

  localparam int SH3 = 29 - FRAC_BITS;
  localparam logic [31:0] RECIP  = 32'((64'd1 << 37) / 64'd45);
  localparam logic [32:0] BIAS   = 33'd3019898880;
  localparam logic [63:0] BIAS_T = 64'd1 << (26 + SH3);
  localparam logic [FRAC_BITS+1:0] ZMARK = {1'b1, {(FRAC_BITS+1){1'b0}}};

  function automatic logic [64*32-1:0] mk_tab();
    logic [64*32-1:0] t;
    t = '0;
    for (int i = 0; i < 64; i++) begin
      t[i*32 +: 32] = 32'((64'(i) << SH3) / 64'd45);
    end
    return t;
  endfunction

  localparam logic [64*32-1:0] FRAC_TAB = mk_tab();

  logic [32:0] u;
  logic [32:0] u1;
  logic [64:0] prod1;
  logic        pos1;
  logic [27:0] q0;
  logic [33:0] r0;
  logic [27:0] q2;
  logic [5:0]  r2;
  logic        pos2;
  logic [31:0] turn;
  logic        fold;
  logic [31:0] turn_f;
  logic        zero_flag;

  assign u = 33'($unsigned(deg) + BIAS);

  always_ff @(posedge clk) begin
    if (en) begin
      u1    <= u;
      prod1 <= 65'(u) * 65'(RECIP);
      pos1  <= !deg[32];
    end
  end

  // quotient by 45 off by at most one
  always_comb begin
    q0 = prod1[64:37];
    r0 = 34'(u1) - 34'(q0) * 34'd45;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos2 <= pos1;
      if (r0 >= 34'd45) begin
        r2 <= 6'(r0 - 34'd45);
        q2 <= q0 + 28'd1;
      end else begin
        r2 <= r0[5:0];
        q2 <= q0;
      end
    end
  end

  always_comb begin
    turn = 32'(64'(q2) << SH3) - BIAS_T[31:0] + FRAC_TAB[32*r2 +: 32];
    fold = turn[31] ^ turn[30];
    turn_f = {turn[31] ^ fold, turn[30:0]};
    zero_flag = pos2 && (r2 == 6'd0) && (q2[FRAC_BITS+1:0] == ZMARK);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane.x     <= CORDIC_K0;
      lane.y     <= '0;
      lane.theta <= {{(LANE_W-32){turn_f[31]}}, turn_f};
      lane.neg   <= fold;
      lane.zero  <= zero_flag;
    end
  end

endmodule

### hw/rtl/afc_cordic_cell.sv
// afc_cordic_cell: one rotation-mode cordic step with its own arctan constant
// depends on afc_pkg
module afc_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           en,
  input  afc_pkg::lane_t a,
  output afc_pkg::lane_t b
);
  import afc_pkg::*;

  localparam logic signed [LANE_W-1:0] ANG = {{(LANE_W-30){1'b0}}, atan_turn(IDX)};

  always_ff @(posedge clk) begin
    if (en) begin
      b.neg  <= a.neg;
      b.zero <= a.zero;
      if (!a.theta[LANE_W-1]) begin
        b.x     <= a.x - (a.y >>> IDX);
        b.y     <= a.y + (a.x >>> IDX);
        b.theta <= a.theta - ANG;
      end else begin
        b.x     <= a.x + (a.y >>> IDX);
        b.y     <= a.y - (a.x >>> IDX);
        b.theta <= a.theta + ANG;
      end
    end
  end

endmodule

### hw/rtl/afc_div_cell.sv
// afc_div_cell: one restoring division step, one quotient bit per cell
// depends on afc_pkg
module afc_div_cell (
  input  logic          clk,
  input  logic          en,
  input  afc_pkg::div_t d,
  output afc_pkg::div_t q
);
  import afc_pkg::*;

  logic [MAG_W:0] trial;
  logic [MAG_W:0] diff;
  logic           take;

  always_comb begin
    trial = {d.rem, d.dq[31]};
    diff  = trial - {1'b0, d.v};
    take  = trial >= {1'b0, d.v};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.v     <= d.v;
      q.big   <= d.big;
      q.czero <= d.czero;
      q.sneg  <= d.sneg;
      q.qneg  <= d.qneg;
      q.zero  <= d.zero;
      q.rem   <= take ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
      q.dq    <= {d.dq[30:0], take};
    end
  end

endmodule

### hw/rtl/affine_transform_compose_2d_top.sv
// affine_transform_compose_2d_top: 2x3 affine matrix from position, rotation, scale,
// skew and pivot; depends on afc_pkg, afc_angle, afc_cordic_cell, afc_div_cell, afc_delay
// throughput: one word per cycle; the cordic chain and the 32-cell tangent divider are
// fully pipelined, and the whole pipe holds while the result word is stalled
// reset clears only the valid bits of the pipe
module affine_transform_compose_2d_top #(
  parameter int FRAC_BITS       = 16,
  parameter int TRIG_ITERATIONS = 18
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  afc_pkg::item_t   item,
  output logic             matrix_valid,
  input  logic             matrix_stall,
  output afc_pkg::matrix_t matrix
);
  import afc_pkg::*;

  localparam int N          = TRIG_ITERATIONS;
  localparam int LAT        = N + 42;
  localparam int SIDE_DEPTH = N + 38;
  localparam int ROT_DEPTH  = DIV_STEPS + 2;
  localparam logic signed [71:0] HALF30 = 72'sd1 <<< 29;
  localparam logic signed [71:0] HALF_F = 72'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [LANE_W-1:0] QTURN = 34'sd1073741824;

  logic           en;
  logic [LAT-1:0] vld;

  assign en           = !(matrix_valid && matrix_stall);
  assign item_stall   = !en;
  assign matrix_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], item_valid};
    end
  end

  // angles: rotation is negated, skews as given
  logic signed [32:0] deg [3];
  lane_t              ln [3][N+1];

  assign deg[0] = -(33'(item.rotation_deg));
  assign deg[1] = 33'(item.skew_x_deg);
  assign deg[2] = 33'(item.skew_y_deg);

  for (genvar l = 0; l < 3; l++) begin : g_lane
    afc_angle #(.FRAC_BITS(FRAC_BITS)) u_angle (
      .clk (clk),
      .en  (en),
      .deg (deg[l]),
      .lane(ln[l][0])
    );
    for (genvar i = 0; i < N; i++) begin : g_cell
      afc_cordic_cell #(.IDX(i)) u_cell (
        .clk(clk),
        .en (en),
        .a  (ln[l][i]),
        .b  (ln[l][i+1])
      );
    end
  end

  // undo the half-turn fold
  logic signed [LANE_W-1:0] cv [3];
  logic signed [LANE_W-1:0] sv [3];
  logic                     zp [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        cv[l] <= ln[l][N].neg ? -ln[l][N].x : ln[l][N].x;
        sv[l] <= ln[l][N].neg ? -ln[l][N].y : ln[l][N].y;
        zp[l] <= ln[l][N].zero;
      end
    end
  end

  // tangent: |s| * 2^F / |c|, quotient bits above 31 flagged up front
  logic [MAG_W-1:0] mag_s [2];
  logic [MAG_W-1:0] mag_c [2];
  logic [MAG_W-1:0] top_s [2];
  div_t             dv [2][DIV_STEPS+1];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      mag_s[k] = sv[k+1][LANE_W-1] ? MAG_W'(-sv[k+1]) : MAG_W'(sv[k+1]);
      mag_c[k] = cv[k+1][LANE_W-1] ? MAG_W'(-cv[k+1]) : MAG_W'(cv[k+1]);
      top_s[k] = mag_s[k] >> (32 - FRAC_BITS);
    end
  end

  for (genvar k = 0; k < 2; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        dv[k][0].rem   <= top_s[k];
        dv[k][0].dq    <= 32'(mag_s[k] << FRAC_BITS);
        dv[k][0].v     <= mag_c[k];
        dv[k][0].big   <= top_s[k] >= mag_c[k];
        dv[k][0].czero <= cv[k+1] == '0;
        dv[k][0].sneg  <= sv[k+1][LANE_W-1];
        dv[k][0].qneg  <= sv[k+1][LANE_W-1] ^ cv[k+1][LANE_W-1];
        dv[k][0].zero  <= zp[k+1];
      end
    end

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
      afc_div_cell u_step (
        .clk(clk),
        .en (en),
        .d  (dv[k][j]),
        .q  (dv[k][j+1])
      );
    end
  end

  logic signed [31:0] tanv [2];
  logic               tov  [2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        if (dv[k][DIV_STEPS].zero) begin
          tanv[k] <= '0;
          tov[k]  <= 1'b0;
        end else if (dv[k][DIV_STEPS].czero) begin
          tanv[k] <= dv[k][DIV_STEPS].sneg ? FX_MIN : FX_MAX;
          tov[k]  <= 1'b1;
        end else if (dv[k][DIV_STEPS].big) begin
          tanv[k] <= dv[k][DIV_STEPS].qneg ? FX_MIN : FX_MAX;
          tov[k]  <= 1'b1;
        end else if (!dv[k][DIV_STEPS].qneg) begin
          tanv[k] <= dv[k][DIV_STEPS].dq[31] ? FX_MAX : dv[k][DIV_STEPS].dq;
          tov[k]  <= dv[k][DIV_STEPS].dq[31];
        end else if (dv[k][DIV_STEPS].dq > 32'h8000_0000) begin
          tanv[k] <= FX_MIN;
          tov[k]  <= 1'b1;
        end else begin
          tanv[k] <= 32'(-dv[k][DIV_STEPS].dq);
          tov[k]  <= 1'b0;
        end
      end
    end
  end

  // rotation trig and side data wait for the tangent
  logic [2*LANE_W-1:0]      rot_cs;
  logic signed [LANE_W-1:0] rot_c;
  logic signed [LANE_W-1:0] rot_s;
  item_t                    side;

  afc_delay #(.WIDTH(2*LANE_W), .DEPTH(ROT_DEPTH)) u_rot_dly (
    .clk(clk),
    .en (en),
    .d  ({cv[0], sv[0]}),
    .q  (rot_cs)
  );

  afc_delay #(.WIDTH($bits(item_t)), .DEPTH(SIDE_DEPTH)) u_side_dly (
    .clk(clk),
    .en (en),
    .d  (item),
    .q  (side)
  );

  assign rot_c = rot_cs[2*LANE_W-1:LANE_W];
  assign rot_s = rot_cs[LANE_W-1:0];

  // scale times trig
  logic signed [65:0] p_xc, p_yc, p_xs, p_ys;
  logic signed [31:0] t1_x, t1_y;
  logic               ov1;
  item_t              s1;

  always_ff @(posedge clk) begin
    if (en) begin
      p_xc <= 66'(side.scale_x) * 66'(rot_c);
      p_yc <= 66'(side.scale_y) * 66'(rot_c);
      p_xs <= 66'(side.scale_x) * 66'(rot_s);
      p_ys <= 66'(side.scale_y) * 66'(rot_s);
      t1_x <= tanv[0];
      t1_y <= tanv[1];
      ov1  <= tov[0] | tov[1];
      s1   <= side;
    end
  end

  logic signed [71:0] sxs_full, sys_full;
  sat_t               sat_xc, sat_yc, sat_xs, sat_ys, sat_mc;

  always_comb begin
    sxs_full = ((72'(p_xs) + HALF30) >>> 30) + 72'(t1_x);
    sys_full = ((72'(p_ys) + HALF30) >>> 30) + 72'(t1_y);
    sat_xc   = sat32((72'(p_xc) + HALF30) >>> 30);
    sat_yc   = sat32((72'(p_yc) + HALF30) >>> 30);
    sat_xs   = sat32(sxs_full);
    sat_ys   = sat32(sys_full);
    sat_mc   = sat32(-sxs_full);
  end

  logic signed [31:0] sxc2, syc2, sxs2, sys2, mc2;
  logic               ov2;
  item_t              s2;

  always_ff @(posedge clk) begin
    if (en) begin
      sxc2 <= sat_xc.val;
      syc2 <= sat_yc.val;
      sxs2 <= sat_xs.val;
      sys2 <= sat_ys.val;
      mc2  <= sat_mc.val;
      ov2  <= ov1 | sat_xc.ov | sat_yc.ov | sat_xs.ov | sat_ys.ov | sat_mc.ov;
      s2   <= s1;
    end
  end

  // pivot products
  logic signed [63:0] c_xc, c_ys, c_xs, c_yc;
  logic signed [31:0] a3, b3, c3, d3, px3, py3;
  logic               ov3;

  always_ff @(posedge clk) begin
    if (en) begin
      c_xc <= 64'(s2.center_x) * 64'(sxc2);
      c_ys <= 64'(s2.center_y) * 64'(sys2);
      c_xs <= 64'(s2.center_x) * 64'(sxs2);
      c_yc <= 64'(s2.center_y) * 64'(syc2);
      a3   <= sxc2;
      b3   <= sys2;
      c3   <= mc2;
      d3   <= syc2;
      px3  <= s2.position_x;
      py3  <= s2.position_y;
      ov3  <= ov2;
    end
  end

  logic signed [71:0] tx_full, ty_full;
  sat_t               sat_tx, sat_ty;

  always_comb begin
    tx_full = 72'(px3) - ((72'(c_xc) + HALF_F) >>> FRAC_BITS)
                       - ((72'(c_ys) + HALF_F) >>> FRAC_BITS);
    ty_full = 72'(py3) + ((72'(c_xs) + HALF_F) >>> FRAC_BITS)
                       - ((72'(c_yc) + HALF_F) >>> FRAC_BITS);
    sat_tx  = sat32(tx_full);
    sat_ty  = sat32(ty_full);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      matrix.m_a      <= a3;
      matrix.m_b      <= b3;
      matrix.m_tx     <= sat_tx.val;
      matrix.m_c      <= c3;
      matrix.m_d      <= d3;
      matrix.m_ty     <= sat_ty.val;
      matrix.overflow <= ov3 | sat_tx.ov | sat_ty.ov;
    end
  end

`ifndef SYNTH
  a_pipe_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipe advanced while result word stalled");

  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> (ln[0][0].theta >= -QTURN && ln[0][0].theta <= QTURN))
    else $error("folded rotation angle outside a quarter turn");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (vld[N+36] && !dv[0][DIV_STEPS].big) |->
      (dv[0][DIV_STEPS].rem < dv[0][DIV_STEPS].v))
    else $error("divider remainder not below divisor");
`endif

endmodule
